>>> rtl/tcht_pkg.sv
package tcht_pkg;

  // Default geometry of the table.
  localparam int TABLE_SLOTS_DEF = 128;
  localparam int KEY_BITS_DEF    = 31;

  // The reported slot index is always this wide, whatever the table size.
  localparam int SLOT_INDEX_W = 7;

  // Request operation codes. The fourth code is unused and changes nothing.
  typedef enum logic [1:0] {
    OP_LOOKUP = 2'd0,
    OP_INSERT = 2'd1,
    OP_DELETE = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_HASH,
    S_PROBE2,
    S_DECIDE
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;    // request taken: capture it and start the hash
    logic clear_wr;  // write one empty slot of the clearing pass
    logic rd_p1;     // read the first candidate slot
    logic rd_p2;     // keep the first slot's data, read the second slot
    logic commit;    // write the table, load the result register
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic hash_done;   // both candidate positions are ready
    logic clear_last;  // the clearing pass is at the last slot
    logic out_free;    // the result register can take a new result
  } sts_t;

endpackage

>>> rtl/tcht_hash.sv
module tcht_hash import tcht_pkg::*; #(
  parameter int TABLE_SLOTS = TABLE_SLOTS_DEF,
  parameter int KEY_BITS    = KEY_BITS_DEF,
  localparam int IDX_W      = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [KEY_BITS-1:0] key,
  output logic                done,
  output logic [IDX_W-1:0]    pos1,
  output logic [IDX_W-1:0]    pos2
);

  localparam bit POW2 = (TABLE_SLOTS & (TABLE_SLOTS - 1)) == 0;

  generate
    if (POW2) begin : g_pow2
      // A power-of-two size makes both positions plain bit fields of the key.
      logic [KEY_BITS-1:0]         key_r;
      logic [KEY_BITS+2*IDX_W-1:0] key_ext;

      always_ff @(posedge clk) begin
        if (start) begin
          key_r <= key;
        end
      end

      assign key_ext = {{(2*IDX_W){1'b0}}, key_r};
      assign pos1    = key_ext[IDX_W-1:0];
      assign pos2    = key_ext[2*IDX_W-1:IDX_W];
      assign done    = 1'b1;
    end else begin : g_recip
      // Both quotients q1 = key / N and q2 = key / (N * N) come from a
      // multiplication by a rounded-up reciprocal. The key is fed 16 bits a
      // cycle, most significant first, into a shift-and-add accumulator.
      // Then pos1 = key - q1 * N and pos2 = q1 - q2 * N; both are below N,
      // so only the low index bits of each term are needed.
      localparam int DIG_W = 16;
      localparam int N_DIG = (KEY_BITS + DIG_W - 1) / DIG_W;
      localparam int XW    = N_DIG * DIG_W;
      localparam int MW    = KEY_BITS + 2;
      localparam int PW    = MW + XW;
      localparam int SH1   = KEY_BITS + $clog2(TABLE_SLOTS);
      localparam int SH2   = KEY_BITS +
                             $clog2(longint'(TABLE_SLOTS) * longint'(TABLE_SLOTS));
      localparam int CNT_W = $clog2(N_DIG + 2);

      function automatic logic [MW-1:0] recip(input logic [63:0] d, input int sh);
        logic [127:0] num;
        num = 128'(1) << sh;
        return MW'(num / 128'(d) + 128'(1));
      endfunction

      localparam logic [MW-1:0] M1 = recip(64'(TABLE_SLOTS), SH1);
      localparam logic [MW-1:0] M2 =
        recip(64'(longint'(TABLE_SLOTS) * longint'(TABLE_SLOTS)), SH2);
      localparam logic [IDX_W-1:0] N_LO      = IDX_W'(TABLE_SLOTS);
      localparam logic [CNT_W-1:0] CNT_ONE   = CNT_W'(1);
      localparam logic [CNT_W-1:0] CNT_START = CNT_W'(N_DIG + 1);

      logic [XW-1:0]       key_x;
      logic [XW-1:0]       key_sh_r;
      logic [IDX_W-1:0]    key_lo_r;
      logic [PW-1:0]       acc1_r, acc1_nxt;
      logic [PW-1:0]       acc2_r, acc2_nxt;
      logic [CNT_W-1:0]    cnt_r;
      logic [IDX_W-1:0]    pos1_r, pos1_nxt;
      logic [IDX_W-1:0]    pos2_r, pos2_nxt;
      logic [DIG_W-1:0]    digit;
      logic [MW+DIG_W-1:0] prod1, prod2;
      logic [IDX_W-1:0]    q1_lo, q2_lo;

      assign key_x = XW'(key);

      always_comb begin
        digit    = key_sh_r[XW-1 -: DIG_W];
        prod1    = {{DIG_W{1'b0}}, M1} * {{MW{1'b0}}, digit};
        prod2    = {{DIG_W{1'b0}}, M2} * {{MW{1'b0}}, digit};
        acc1_nxt = (acc1_r << DIG_W) + PW'(prod1);
        acc2_nxt = (acc2_r << DIG_W) + PW'(prod2);
        q1_lo    = IDX_W'(acc1_r >> SH1);
        q2_lo    = IDX_W'(acc2_r >> SH2);
        pos1_nxt = key_lo_r - q1_lo * N_LO;
        pos2_nxt = q1_lo - q2_lo * N_LO;
      end

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          cnt_r <= '0;
        end else if (start) begin
          cnt_r <= CNT_START;
        end else if (cnt_r != '0) begin
          cnt_r <= cnt_r - CNT_ONE;
        end
      end

      always_ff @(posedge clk) begin
        if (start) begin
          key_sh_r <= key_x;
          key_lo_r <= key_x[IDX_W-1:0];
          acc1_r   <= '0;
          acc2_r   <= '0;
        end else if (cnt_r > CNT_ONE) begin
          key_sh_r <= key_sh_r << DIG_W;
          acc1_r   <= acc1_nxt;
          acc2_r   <= acc2_nxt;
        end
      end

      always_ff @(posedge clk) begin
        if (cnt_r == CNT_ONE) begin
          pos1_r <= pos1_nxt;
          pos2_r <= pos2_nxt;
        end
      end

      assign pos1 = pos1_r;
      assign pos2 = pos2_r;
      assign done = cnt_r == '0;
    end
  endgenerate

endmodule

>>> rtl/tcht_datapath.sv
module tcht_datapath import tcht_pkg::*; #(
  parameter int TABLE_SLOTS = TABLE_SLOTS_DEF,
  parameter int KEY_BITS    = KEY_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  cmd_t                    cmd,
  input  logic [1:0]              in_operation,
  input  logic [KEY_BITS-1:0]     in_key,
  input  logic                    out_ready,
  output sts_t                    sts,
  output logic                    out_valid,
  output logic                    out_ok,
  output logic [SLOT_INDEX_W-1:0] out_slot_index,
  output logic                    out_second_probe
);

  localparam int IDX_W = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(TABLE_SLOTS - 1);
  localparam logic [IDX_W-1:0] IDX_ONE  = IDX_W'(1);

  // Each entry holds a valid bit above the stored key.
  logic [KEY_BITS:0] mem [TABLE_SLOTS];

  logic [1:0]          op_r;
  logic [KEY_BITS-1:0] key_r;
  logic [IDX_W-1:0]    clr_cnt_r;
  logic [KEY_BITS:0]   rd_q_r;
  logic [KEY_BITS:0]   first_q_r;
  logic [IDX_W-1:0]    pos1, pos2;
  logic                hash_done;

  logic                out_valid_r, out_valid_nxt;
  logic                out_ok_r;
  logic [SLOT_INDEX_W-1:0] out_idx_r;
  logic                out_sec_r;

  logic                hit1, hit2;
  logic                dec_ok, dec_sec, dec_wr, dec_wr_valid;
  logic [IDX_W-1:0]    dec_idx;
  logic [IDX_W+SLOT_INDEX_W-1:0] idx_ext;

  logic                mem_we;
  logic [IDX_W-1:0]    mem_waddr, mem_raddr;
  logic [KEY_BITS:0]   mem_wdata;

  tcht_hash #(
    .TABLE_SLOTS(TABLE_SLOTS),
    .KEY_BITS   (KEY_BITS)
  ) u_hash (
    .clk  (clk),
    .rst_n(rst_n),
    .start(cmd.accept),
    .key  (in_key),
    .done (hash_done),
    .pos1 (pos1),
    .pos2 (pos2)
  );

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_r  <= in_operation;
      key_r <= in_key;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (cmd.clear_wr) begin
      clr_cnt_r <= clr_cnt_r + IDX_ONE;
    end
  end

  // Outcome of the two probes, taken while the second slot's data is held.
  always_comb begin
    hit1         = first_q_r[KEY_BITS] && (first_q_r[KEY_BITS-1:0] == key_r);
    hit2         = rd_q_r[KEY_BITS] && (rd_q_r[KEY_BITS-1:0] == key_r);
    dec_ok       = 1'b0;
    dec_sec      = 1'b0;
    dec_idx      = '0;
    dec_wr       = 1'b0;
    dec_wr_valid = 1'b0;
    unique case (op_r)
      OP_LOOKUP, OP_DELETE: begin
        if (hit1) begin
          dec_ok  = 1'b1;
          dec_idx = pos1;
        end else if (hit2) begin
          dec_ok  = 1'b1;
          dec_idx = pos2;
          dec_sec = 1'b1;
        end
        dec_wr = dec_ok && (op_r == OP_DELETE);
      end
      OP_INSERT: begin
        if (!first_q_r[KEY_BITS]) begin
          dec_ok  = 1'b1;
          dec_idx = pos1;
        end else if (!rd_q_r[KEY_BITS]) begin
          dec_ok  = 1'b1;
          dec_idx = pos2;
          dec_sec = 1'b1;
        end
        dec_wr       = dec_ok;
        dec_wr_valid = 1'b1;
      end
      default: begin
      end
    endcase
    idx_ext = {{SLOT_INDEX_W{1'b0}}, dec_idx};
  end

  always_comb begin
    mem_we    = cmd.clear_wr || (cmd.commit && dec_wr);
    mem_waddr = cmd.clear_wr ? clr_cnt_r : dec_idx;
    mem_wdata = cmd.clear_wr ? '0 : {dec_wr_valid, key_r};
    mem_raddr = cmd.rd_p2 ? pos2 : pos1;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (cmd.rd_p1 || cmd.rd_p2) begin
      rd_q_r <= mem[mem_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_p2) begin
      first_q_r <= rd_q_r;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_ok_r  <= dec_ok;
      out_idx_r <= idx_ext[SLOT_INDEX_W-1:0];
      out_sec_r <= dec_sec;
    end
  end

  assign sts.hash_done  = hash_done;
  assign sts.clear_last = clr_cnt_r == IDX_LAST;
  assign sts.out_free   = !out_valid_r || out_ready;

  assign out_valid        = out_valid_r;
  assign out_ok           = out_ok_r;
  assign out_slot_index   = out_idx_r;
  assign out_second_probe = out_sec_r;

endmodule

>>> rtl/tcht_ctrl.sv
module tcht_ctrl import tcht_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  input  sts_t sts,
  output logic in_ready,
  output cmd_t cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: begin
        if (sts.clear_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_HASH;
        end
      end
      S_HASH: begin
        if (sts.hash_done) begin
          state_nxt = S_PROBE2;
        end
      end
      S_PROBE2: begin
        state_nxt = S_DECIDE;
      end
      S_DECIDE: begin
        if (sts.out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  always_comb begin
    in_ready     = state_r == S_IDLE;
    cmd.accept   = (state_r == S_IDLE) && in_valid;
    cmd.clear_wr = state_r == S_CLEAR;
    cmd.rd_p1    = (state_r == S_HASH) && sts.hash_done;
    cmd.rd_p2    = state_r == S_PROBE2;
    cmd.commit   = (state_r == S_DECIDE) && sts.out_free;
  end

endmodule

>>> rtl/two_choice_hash_table.sv
// Two-choice hash table: a table of TABLE_SLOTS key slots in which each key
// may sit at one of two candidate slots, key mod TABLE_SLOTS or
// (key / TABLE_SLOTS) mod TABLE_SLOTS.
// Requests enter on the in_ channel (in_operation: lookup, insert, delete;
// in_key) with a valid/ready handshake. Each request gives exactly one
// result on the out_ channel: out_ok, out_slot_index (zero on a miss) and
// out_second_probe, also under valid/ready.
// One request is in work at a time. After acceptance a request passes
// through the hash, second-probe and decide states before the next one is
// accepted, and its result is registered when it commits. With a
// power-of-two table size both positions are bit fields of the key; for
// other sizes the hash unit forms both positions by reciprocal
// multiplication, 16 key bits a cycle, and holds the hash state until done.
// The two probes share the single read port of the slot memory.
// After reset the block runs a clearing pass that marks every slot empty;
// in_ready stays low until it is done.
// The result sits in an output register, so the next request is accepted
// while a result waits; a request whose result finds that register still
// full holds its table write until the receiver takes the old result.
module two_choice_hash_table import tcht_pkg::*; #(
  parameter int TABLE_SLOTS = TABLE_SLOTS_DEF,
  parameter int KEY_BITS    = KEY_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [1:0]              in_operation,
  input  logic [KEY_BITS-1:0]     in_key,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic                    out_ok,
  output logic [SLOT_INDEX_W-1:0] out_slot_index,
  output logic                    out_second_probe
);

  cmd_t cmd;
  sts_t sts;

  // The controller sequences hashing, the two probes and the commit.
  tcht_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .sts     (sts),
    .in_ready(in_ready),
    .cmd     (cmd)
  );

  // The datapath holds the slot memory, the hash unit and the result register.
  tcht_datapath #(
    .TABLE_SLOTS(TABLE_SLOTS),
    .KEY_BITS   (KEY_BITS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .in_operation    (in_operation),
    .in_key          (in_key),
    .out_ready       (out_ready),
    .sts             (sts),
    .out_valid       (out_valid),
    .out_ok          (out_ok),
    .out_slot_index  (out_slot_index),
    .out_second_probe(out_second_probe)
  );

  // Only one request is in work: an accepted request closes the input.
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("request accepted while another is in work");

  // A commit always presents its result in the following cycle.
  a_commit_shows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> out_valid)
    else $error("committed result not presented");

  // No request is taken while the clearing pass still runs.
  a_clear_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.clear_wr |-> !in_ready)
    else $error("input open during clearing pass");

  // A failed request reports no slot.
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ok) |-> (out_slot_index == '0 && !out_second_probe))
    else $error("miss reported with a slot");

endmodule

>>> tb/tb_two_choice_hash_table.sv
module tb_two_choice_hash_table;
  timeunit 1ns;
  timeprecision 1ps;

  import tcht_pkg::*;

  // Geometry of the instance under test; it runs with the package defaults.
  localparam int SLOTS = TABLE_SLOTS_DEF;
  localparam int KEY_W = KEY_BITS_DEF;
  localparam int IDX_W = SLOT_INDEX_W;

  // The fourth operation code has no name in the package. It must be
  // accepted, answered with a miss and leave the slots alone.
  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam int RANDOM_REQUESTS = 800;
  localparam int QUIET_TAIL      = 100;
  localparam int DRAIN_CYCLES    = 16;
  localparam int CYCLE_LIMIT     = 100000;
  localparam int MAX_REPORTS     = 20;

  // Directed keys. The all-ones key and key zero each have both candidates
  // on one slot (127 and 0). The three pair keys share first slot 3 and
  // second slot 9 and differ only in their upper bits.
  localparam logic [KEY_W-1:0] KEY_MAX    = '1;
  localparam logic [KEY_W-1:0] KEY_ZERO   = '0;
  localparam logic [KEY_W-1:0] KEY_LONELY = KEY_W'(5);
  localparam logic [KEY_W-1:0] KEY_PAIR_A = KEY_W'((0 << 14) | (9 << 7) | 3);
  localparam logic [KEY_W-1:0] KEY_PAIR_B = KEY_W'((1 << 14) | (9 << 7) | 3);
  localparam logic [KEY_W-1:0] KEY_PAIR_C = KEY_W'((2 << 14) | (9 << 7) | 3);

  typedef struct packed {
    logic             ok;
    logic [IDX_W-1:0] slot_index;
    logic             second_probe;
  } slot_reply_t;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    in_valid = 1'b0;
  logic                    in_ready;
  logic [1:0]              in_operation = 2'd0;
  logic [KEY_W-1:0]        in_key = '0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic                    out_ok;
  logic [IDX_W-1:0]        out_slot_index;
  logic                    out_second_probe;

  // The testbench's own image of the slots, updated as each request is
  // accepted. Keys are only compared where the occupancy bit is set, so the
  // unwritten key entries never matter.
  logic [KEY_W-1:0] slot_key_copy [SLOTS];
  logic             slot_used_copy [SLOTS];

  // Replies worked out at acceptance, oldest first.
  slot_reply_t expected_replies [$];
  slot_reply_t oldest_reply;

  int error_count    = 0;
  int replies_seen   = 0;
  int requests_sent  = 0;
  int directed_count = 0;
  int hit_count      = 0;
  int stored_count   = 0;
  int refused_count  = 0;
  int cycle_count    = 0;
  int stall_left     = 0;

  // Chance in percent that either side starts an idle burst at its next
  // opportunity. Zero gives back-to-back traffic.
  int idle_pct = 0;

  two_choice_hash_table #(
    .TABLE_SLOTS(SLOTS),
    .KEY_BITS   (KEY_W)
  ) uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_operation    (in_operation),
    .in_key          (in_key),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_ok          (out_ok),
    .out_slot_index  (out_slot_index),
    .out_second_probe(out_second_probe)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Hard stop in case a request or a reply never completes its handshake.
  // The limit covers the clearing pass and several times the slowest run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timeout: no progress after %0d cycles, %0d replies outstanding.",
               cycle_count, expected_replies.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (error_count < MAX_REPORTS) begin
      $display("Mismatch on reply %0d: %s is %0h, expected %0h.",
               replies_seen, what, got, want);
    end
    error_count++;
  endtask

  // Works out the reply to one accepted request and applies its effect to
  // the slot image. Lookup and delete probe the first candidate, then the
  // second; when both candidates are the same slot a hit counts as first.
  // Insert takes the first empty candidate and never evicts.
  task automatic predict_reply(input logic [1:0] op, input logic [KEY_W-1:0] key);
    int unsigned key_val;
    int unsigned first_pos;
    int unsigned second_pos;
    slot_reply_t reply;
    key_val    = 32'(key);
    first_pos  = key_val % SLOTS;
    second_pos = (key_val / SLOTS) % SLOTS;
    reply      = '0;
    case (op)
      OP_LOOKUP, OP_DELETE: begin
        if (slot_used_copy[first_pos] && slot_key_copy[first_pos] == key) begin
          reply.ok         = 1'b1;
          reply.slot_index = IDX_W'(first_pos);
          if (op == OP_DELETE) slot_used_copy[first_pos] = 1'b0;
        end else if (slot_used_copy[second_pos] && slot_key_copy[second_pos] == key) begin
          reply.ok           = 1'b1;
          reply.slot_index   = IDX_W'(second_pos);
          reply.second_probe = 1'b1;
          if (op == OP_DELETE) slot_used_copy[second_pos] = 1'b0;
        end
        if (reply.ok) hit_count++;
      end
      OP_INSERT: begin
        if (!slot_used_copy[first_pos]) begin
          slot_key_copy[first_pos]  = key;
          slot_used_copy[first_pos] = 1'b1;
          reply.ok                  = 1'b1;
          reply.slot_index          = IDX_W'(first_pos);
        end else if (!slot_used_copy[second_pos]) begin
          slot_key_copy[second_pos]  = key;
          slot_used_copy[second_pos] = 1'b1;
          reply.ok                   = 1'b1;
          reply.slot_index           = IDX_W'(second_pos);
          reply.second_probe         = 1'b1;
        end
        if (reply.ok) stored_count++;
        else refused_count++;
      end
      default: begin
      end
    endcase
    expected_replies.push_back(reply);
  endtask

  // Presents one request and returns at the edge where it is accepted. An
  // idle burst may come first. Valid is only lowered for a burst, so a
  // request that follows straight on keeps valid high and just changes the
  // payload in the step of the previous acceptance.
  task automatic send_request(input logic [1:0] op, input logic [KEY_W-1:0] key);
    if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_operation <= op;
    in_key       <= key;
    @(posedge clk);
    while (in_ready !== 1'b1) @(posedge clk);
    predict_reply(op, key);
    requests_sent++;
  endtask

  // The receiver starts stall bursts at the current idle rate.
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
    end else if (rst_n && idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      stall_left = $urandom_range(1, 6);
    end
    out_ready <= (stall_left == 0);
  end

  // Every reply taken is checked field by field against the oldest
  // expectation. Values are sampled as they stood before the edge.
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && out_ready) begin
      if (expected_replies.size() == 0) begin
        report_mismatch("reply with no request waiting", 32'(out_ok), 32'(0));
      end else begin
        oldest_reply = expected_replies.pop_front();
        if (out_ok !== oldest_reply.ok)
          report_mismatch("ok", 32'(out_ok), 32'(oldest_reply.ok));
        if (out_slot_index !== oldest_reply.slot_index)
          report_mismatch("slot_index", 32'(out_slot_index),
                          32'(oldest_reply.slot_index));
        if (out_second_probe !== oldest_reply.second_probe)
          report_mismatch("second_probe", 32'(out_second_probe),
                          32'(oldest_reply.second_probe));
      end
      replies_seen++;
    end
  end

  // Right after the clearing pass every slot must read as empty.
  task automatic test_empty_table();
    send_request(OP_LOOKUP, KEY_LONELY);
    send_request(OP_DELETE, KEY_LONELY);
    send_request(OP_LOOKUP, KEY_MAX);
  endtask

  // Keys whose two candidates are the same slot: the second insert must be
  // refused, and hits must be reported as first-candidate hits.
  task automatic test_shared_candidate();
    send_request(OP_INSERT, KEY_ZERO);
    send_request(OP_INSERT, KEY_ZERO);
    send_request(OP_LOOKUP, KEY_ZERO);
    send_request(OP_INSERT, KEY_MAX);
    send_request(OP_LOOKUP, KEY_MAX);
  endtask

  // A duplicate insert spills into the second candidate; a different key for
  // the same pair finds both slots full and is refused.
  task automatic test_two_candidates();
    send_request(OP_INSERT, KEY_PAIR_A);
    send_request(OP_INSERT, KEY_PAIR_A);
    send_request(OP_LOOKUP, KEY_PAIR_A);
    send_request(OP_INSERT, KEY_PAIR_B);
  endtask

  // Delete clears only the first matching slot, so the duplicate is then
  // found through the second probe. Misses on full slots holding other keys
  // must not disturb anything.
  task automatic test_delete();
    send_request(OP_DELETE, KEY_PAIR_A);
    send_request(OP_LOOKUP, KEY_PAIR_A);
    send_request(OP_INSERT, KEY_PAIR_B);
    send_request(OP_INSERT, KEY_PAIR_C);
    send_request(OP_LOOKUP, KEY_PAIR_C);
    send_request(OP_DELETE, KEY_PAIR_C);
    send_request(OP_DELETE, KEY_PAIR_A);
    send_request(OP_DELETE, KEY_PAIR_A);
  endtask

  // The unused operation code must leave a stored key where it is.
  task automatic test_unused_code();
    send_request(OP_UNUSED, KEY_MAX);
    send_request(OP_LOOKUP, KEY_MAX);
    send_request(OP_DELETE, KEY_MAX);
    send_request(OP_DELETE, KEY_ZERO);
    send_request(OP_UNUSED, KEY_ZERO);
  endtask

  // Random traffic. Most keys are crowded onto eight first and eight second
  // slots so that inserts collide, spill and get refused, and most lookups
  // and deletes reuse recently inserted keys so that they hit. A quarter of
  // the fresh keys are fully random to exercise every key bit. The idle
  // rate changes every hundred requests and drops to zero for the tail.
  task automatic test_random_traffic();
    int unsigned      roll;
    logic [1:0]       op;
    logic [KEY_W-1:0] key;
    logic [KEY_W-1:0] live_keys [$];
    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      if (n >= RANDOM_REQUESTS - QUIET_TAIL) begin
        idle_pct = 0;
      end else if (n % 100 == 0) begin
        case ($urandom_range(0, 2))
          0: idle_pct = 0;
          1: idle_pct = 15;
          default: idle_pct = 40;
        endcase
      end
      roll = $urandom_range(0, 99);
      if (roll < 35) op = OP_INSERT;
      else if (roll < 65) op = OP_LOOKUP;
      else if (roll < 95) op = OP_DELETE;
      else op = OP_UNUSED;

      if (live_keys.size() != 0 &&
          (op == OP_INSERT ? $urandom_range(0, 7) == 0 : $urandom_range(0, 3) != 0)) begin
        key = live_keys[$urandom_range(0, live_keys.size() - 1)];
      end else if ($urandom_range(0, 3) == 0) begin
        key = KEY_W'($urandom());
      end else begin
        key = {(KEY_W - 14)'($urandom()), 7'($urandom_range(0, 7)),
               7'($urandom_range(0, 7))};
      end

      send_request(op, key);
      if (op == OP_INSERT) begin
        live_keys.push_back(key);
        if (live_keys.size() > 24) void'(live_keys.pop_front());
      end
    end
  endtask

  initial begin
    for (int i = 0; i < SLOTS; i++) begin
      slot_key_copy[i]  = '0;
      slot_used_copy[i] = 1'b0;
    end
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    idle_pct = 30;
    test_empty_table();
    test_shared_candidate();
    test_two_candidates();
    test_delete();
    test_unused_code();
    directed_count = requests_sent;
    test_random_traffic();
    in_valid <= 1'b0;

    // Wait for the last replies, then a few more cycles to catch any extra
    // reply the block might still produce.
    while (expected_replies.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d requests: %0d directed corner cases, then crowded random traffic.",
             requests_sent, directed_count);
    $display("Hits on lookup or delete %0d, inserts stored %0d, refused %0d, mismatches %0d.",
             hit_count, stored_count, refused_count, error_count);
    if (error_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
